// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk and held off while rstn is low.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: label");

// Same check on the block's own clock and reset.
`define ASSERT_SRS(label, prop) \
    `ASSERT_CLK(label, aclk, aresetn, prop)

`endif

// ----- sv/srs_pkg.sv -----
package srs_pkg;

    // Width of the tick counters; they saturate at their all-ones value.
    localparam int TIMER_BITS = 17;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Configuration register widths.
    localparam int SETUP_W = 3;
    localparam int DUR_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DUR_W;

    // Width used when comparing a counter to a duration.
    localparam int CMP_W = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_SETUP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDICATOR_SETUP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DONE_SETUP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_DURATION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INDICATOR_DURATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TIME       = 3'd5;

    // Bits of a setup register.
    localparam int SETUP_EN  = 0;
    localparam int SETUP_INV = 1;
    localparam int SETUP_SEL = 2;

    // Phase codes.
    localparam logic [1:0] PH_READY   = 2'd0;
    localparam logic [1:0] PH_PREPARE = 2'd1;
    localparam logic [1:0] PH_WORK    = 2'd2;
    localparam logic [1:0] PH_FINAL   = 2'd3;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [SETUP_W-1:0]    setup_t;
    typedef logic [DUR_W-1:0]      dur_t;

    // Saturating count of one tick.
    function automatic timer_t timer_bump(input timer_t v);
        timer_bump = (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    // True when the elapsed count exceeds the duration.
    function automatic logic expired(input timer_t v, input dur_t d);
        logic [CMP_W-1:0] ve;
        logic [CMP_W-1:0] de;
        ve = CMP_W'(v);
        de = CMP_W'(d);
        expired = (ve > de);
    endfunction

endpackage

// ----- sv/service_relay_sequencer.sv -----
// Service relay sequencer. One input item is one pass of the control loop and
// yields exactly one result item. The item is processed by a single stage of
// logic between the state registers and the result register, so one item is
// accepted per clock: s_ready stays high while the result register is empty or
// being taken, and the result appears in the cycle after acceptance. The block
// runs a ready/prepare/work/final sequence, drives two latched relays from the
// indicator and control one-shot pulses, and ends the work phase on the
// qualified done sensor or on the service timeout. Durations and timeout are
// in 10 ms ticks; write configuration only while no item is in flight.
module service_relay_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_tick_10ms,
    input  logic                            s_event_valid,
    input  logic                            s_evt_prepare,
    input  logic                            s_evt_indicator,
    input  logic                            s_evt_control,
    input  logic                            s_sensor_one,
    input  logic                            s_sensor_two,
    // Result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_relay_one,
    output logic                            m_relay_two,
    output logic                            m_done_pulse,
    output logic                            m_timeout_pulse,
    output logic                            m_ready_flag,
    output logic [1:0]                      m_phase
);

    // Configuration registers.
    srs_pkg::setup_t control_setup_reg;
    srs_pkg::setup_t indicator_setup_reg;
    srs_pkg::setup_t done_setup_reg;
    srs_pkg::dur_t   control_duration_reg;
    srs_pkg::dur_t   indicator_duration_reg;
    srs_pkg::dur_t   service_time_reg;

    // Sequencer state.
    logic [1:0]      phase_reg, phase_next;
    logic            ind_armed_reg, ind_armed_next;
    logic            ctl_armed_reg, ctl_armed_next;
    srs_pkg::timer_t ind_elapsed_reg, ind_elapsed_next;
    srs_pkg::timer_t ctl_elapsed_reg, ctl_elapsed_next;
    srs_pkg::timer_t work_elapsed_reg, work_elapsed_next;
    logic            relay_one_reg, relay_one_next;
    logic            relay_two_reg, relay_two_next;

    // Result register.
    logic            out_valid_reg;
    logic            done_pulse_reg, done_pulse_next;
    logic            timeout_pulse_reg, timeout_pulse_next;
    logic            ready_flag_reg, ready_flag_next;

    logic            accept;
    logic            done_act;
    logic            done_sensor;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_setup_reg      <= '0;
            indicator_setup_reg    <= '0;
            done_setup_reg         <= '0;
            control_duration_reg   <= '0;
            indicator_duration_reg <= '0;
            service_time_reg       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srs_pkg::REG_CONTROL_SETUP:
                    control_setup_reg <= cfg_wdata[srs_pkg::SETUP_W-1:0];
                srs_pkg::REG_INDICATOR_SETUP:
                    indicator_setup_reg <= cfg_wdata[srs_pkg::SETUP_W-1:0];
                srs_pkg::REG_DONE_SETUP:
                    done_setup_reg <= cfg_wdata[srs_pkg::SETUP_W-1:0];
                srs_pkg::REG_CONTROL_DURATION:
                    control_duration_reg <= cfg_wdata[srs_pkg::DUR_W-1:0];
                srs_pkg::REG_INDICATOR_DURATION:
                    indicator_duration_reg <= cfg_wdata[srs_pkg::DUR_W-1:0];
                srs_pkg::REG_SERVICE_TIME:
                    service_time_reg <= cfg_wdata[srs_pkg::DUR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Qualified done signal from the current sensor pins.
    assign done_sensor = done_setup_reg[srs_pkg::SETUP_SEL] ? s_sensor_two : s_sensor_one;
    assign done_act    = done_setup_reg[srs_pkg::SETUP_EN] &&
                         (done_sensor ^ done_setup_reg[srs_pkg::SETUP_INV]);

    // One pass of the loop. Relay drives are applied in order, so a later
    // drive to the same relay overrides an earlier one.
    always_comb begin
        logic lvl;
        phase_next         = phase_reg;
        ind_armed_next     = ind_armed_reg;
        ctl_armed_next     = ctl_armed_reg;
        ind_elapsed_next   = ind_elapsed_reg;
        ctl_elapsed_next   = ctl_elapsed_reg;
        work_elapsed_next  = work_elapsed_reg;
        relay_one_next     = relay_one_reg;
        relay_two_next     = relay_two_reg;
        done_pulse_next    = 1'b0;
        timeout_pulse_next = 1'b0;
        ready_flag_next    = !done_act;
        lvl                = 1'b0;

        // Timers advance on a tick and stick at their maximum.
        if (s_tick_10ms) begin
            ind_elapsed_next  = srs_pkg::timer_bump(ind_elapsed_reg);
            ctl_elapsed_next  = srs_pkg::timer_bump(ctl_elapsed_reg);
            work_elapsed_next = srs_pkg::timer_bump(work_elapsed_reg);
        end

        // Expired pulses switch off, indicator first.
        if (ind_armed_reg && srs_pkg::expired(ind_elapsed_next, indicator_duration_reg)) begin
            ind_armed_next = 1'b0;
            if (indicator_setup_reg[srs_pkg::SETUP_EN]) begin
                lvl = indicator_setup_reg[srs_pkg::SETUP_INV];
                if (indicator_setup_reg[srs_pkg::SETUP_SEL]) relay_two_next = lvl;
                else relay_one_next = lvl;
            end
        end
        if (ctl_armed_reg && srs_pkg::expired(ctl_elapsed_next, control_duration_reg)) begin
            ctl_armed_next = 1'b0;
            if (control_setup_reg[srs_pkg::SETUP_EN]) begin
                lvl = control_setup_reg[srs_pkg::SETUP_INV];
                if (control_setup_reg[srs_pkg::SETUP_SEL]) relay_two_next = lvl;
                else relay_one_next = lvl;
            end
        end

        // Phase machine.
        case (phase_reg)
            srs_pkg::PH_READY: begin
                if (s_event_valid && s_evt_prepare) begin
                    phase_next     = srs_pkg::PH_PREPARE;
                    ind_armed_next = 1'b0;
                    if (indicator_setup_reg[srs_pkg::SETUP_EN]) begin
                        lvl = indicator_setup_reg[srs_pkg::SETUP_INV];
                        if (indicator_setup_reg[srs_pkg::SETUP_SEL]) relay_two_next = lvl;
                        else relay_one_next = lvl;
                    end
                end
            end
            srs_pkg::PH_PREPARE: begin
                if (s_event_valid) begin
                    if (s_evt_indicator) ind_elapsed_next = '0;
                    ind_armed_next = s_evt_indicator;
                    if (indicator_setup_reg[srs_pkg::SETUP_EN]) begin
                        lvl = s_evt_indicator ^ indicator_setup_reg[srs_pkg::SETUP_INV];
                        if (indicator_setup_reg[srs_pkg::SETUP_SEL]) relay_two_next = lvl;
                        else relay_one_next = lvl;
                    end
                    if (s_evt_control) begin
                        ctl_elapsed_next  = '0;
                        ctl_armed_next    = 1'b1;
                        work_elapsed_next = '0;
                        phase_next        = srs_pkg::PH_WORK;
                        if (control_setup_reg[srs_pkg::SETUP_EN]) begin
                            lvl = !control_setup_reg[srs_pkg::SETUP_INV];
                            if (control_setup_reg[srs_pkg::SETUP_SEL]) relay_two_next = lvl;
                            else relay_one_next = lvl;
                        end
                    end else begin
                        phase_next = srs_pkg::PH_READY;
                    end
                end
            end
            srs_pkg::PH_WORK: begin
                if (srs_pkg::expired(work_elapsed_next, service_time_reg)) begin
                    timeout_pulse_next = 1'b1;
                    phase_next         = srs_pkg::PH_FINAL;
                end else if (done_act) begin
                    ctl_armed_next  = 1'b0;
                    done_pulse_next = 1'b1;
                    phase_next      = srs_pkg::PH_FINAL;
                    if (control_setup_reg[srs_pkg::SETUP_EN]) begin
                        lvl = control_setup_reg[srs_pkg::SETUP_INV];
                        if (control_setup_reg[srs_pkg::SETUP_SEL]) relay_two_next = lvl;
                        else relay_one_next = lvl;
                    end
                end
            end
            default: begin
                phase_next = srs_pkg::PH_READY;
            end
        endcase
    end

    // State advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= srs_pkg::PH_READY;
            ind_armed_reg    <= 1'b0;
            ctl_armed_reg    <= 1'b0;
            ind_elapsed_reg  <= '0;
            ctl_elapsed_reg  <= '0;
            work_elapsed_reg <= '0;
            relay_one_reg    <= 1'b0;
            relay_two_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            ind_armed_reg    <= ind_armed_next;
            ctl_armed_reg    <= ctl_armed_next;
            ind_elapsed_reg  <= ind_elapsed_next;
            ctl_elapsed_reg  <= ctl_elapsed_next;
            work_elapsed_reg <= work_elapsed_next;
            relay_one_reg    <= relay_one_next;
            relay_two_reg    <= relay_two_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= s_valid;
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            done_pulse_reg    <= done_pulse_next;
            timeout_pulse_reg <= timeout_pulse_next;
            ready_flag_reg    <= ready_flag_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_relay_one     = relay_one_reg;
    assign m_relay_two     = relay_two_reg;
    assign m_done_pulse    = done_pulse_reg;
    assign m_timeout_pulse = timeout_pulse_reg;
    assign m_ready_flag    = ready_flag_reg;
    assign m_phase         = phase_reg;

endmodule

// ----- sv/srs_checker.sv -----
`include "assert_macros.svh"

// Port-level checks for the service relay sequencer.
module srs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_relay_one,
    input logic       m_relay_two,
    input logic       m_done_pulse,
    input logic       m_timeout_pulse,
    input logic       m_ready_flag,
    input logic [1:0] m_phase
);

    // Either end of work was reported in the shown item.
    logic       work_end;
    // Result fields that must hold while the item waits.
    logic [4:0] shown;

    assign work_end = m_done_pulse || m_timeout_pulse;
    assign shown    = {m_relay_one, m_relay_two, m_ready_flag, m_phase};

    // A work phase ends only one way per item.
    `ASSERT_SRS(a_one_end, m_valid |-> !(m_done_pulse && m_timeout_pulse))

    // Either end of work leaves the block in the final phase.
    `ASSERT_SRS(a_end_final, (m_valid && work_end) |-> (m_phase == srs_pkg::PH_FINAL))

    // An empty result register never blocks the input side.
    `ASSERT_SRS(a_empty_ready, !m_valid |-> s_ready)

    // An accepted item shows up as a result on the next cycle.
    `ASSERT_SRS(a_accept_result, (s_valid && s_ready) |=> m_valid)

    // A stalled item holds its payload.
    `ASSERT_SRS(a_hold, (m_valid && !m_ready) |=> (m_valid && $stable(shown)))

endmodule

bind service_relay_sequencer srs_checker u_srs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_relay_one     (m_relay_one),
    .m_relay_two     (m_relay_two),
    .m_done_pulse    (m_done_pulse),
    .m_timeout_pulse (m_timeout_pulse),
    .m_ready_flag    (m_ready_flag),
    .m_phase         (m_phase)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    typedef srs_pkg::setup_t setup_t;
    typedef srs_pkg::dur_t   dur_t;
    typedef srs_pkg::timer_t timer_t;

    localparam int IDLE_LIMIT = 2000;
    localparam int PAD_W = srs_pkg::CFG_DATA_W - srs_pkg::SETUP_W;
    localparam int RANDOM_SETTINGS = 10;
    localparam int ITEMS_PER_SETTING = 125;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [srs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = srs_pkg::REG_SERVICE_TIME + 3'd1;
    localparam logic [srs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = srs_pkg::REG_SERVICE_TIME + 3'd2;

    // One pass of the control loop as it enters, and what it leaves behind.
    typedef struct packed {
        logic tick;
        logic ev_valid;
        logic prepare;
        logic indicator;
        logic control;
        logic pin_one;
        logic pin_two;
    } loop_item_t;

    typedef struct packed {
        logic       relay_one;
        logic       relay_two;
        logic       done_hit;
        logic       timeout_hit;
        logic       ready_flag;
        logic [1:0] phase;
    } loop_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                           cfg_wr_en = 1'b0;
    logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [srs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic s_tick_10ms = 1'b0;
    logic s_event_valid = 1'b0;
    logic s_evt_prepare = 1'b0;
    logic s_evt_indicator = 1'b0;
    logic s_evt_control = 1'b0;
    logic s_sensor_one = 1'b0;
    logic s_sensor_two = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_relay_one;
    logic       m_relay_two;
    logic       m_done_pulse;
    logic       m_timeout_pulse;
    logic       m_ready_flag;
    logic [1:0] m_phase;

    // Predictor copy of the registers.
    setup_t ctl_setup = '0;
    setup_t ind_setup = '0;
    setup_t done_cfg = '0;
    dur_t   ctl_dur = '0;
    dur_t   ind_dur = '0;
    dur_t   svc_time = '0;

    // Predictor copy of the sequencer state.
    logic [1:0] phase_q = srs_pkg::PH_READY;
    logic       ind_armed = 1'b0;
    logic       ctl_armed = 1'b0;
    timer_t     ind_elapsed = '0;
    timer_t     ctl_elapsed = '0;
    timer_t     work_elapsed = '0;
    logic       relay_one_q = 1'b0;
    logic       relay_two_q = 1'b0;

    loop_result_t expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int done_ends = 0;
    int timeout_ends = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    service_relay_sequencer DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_tick_10ms     (s_tick_10ms),
        .s_event_valid   (s_event_valid),
        .s_evt_prepare   (s_evt_prepare),
        .s_evt_indicator (s_evt_indicator),
        .s_evt_control   (s_evt_control),
        .s_sensor_one    (s_sensor_one),
        .s_sensor_two    (s_sensor_two),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_relay_one     (m_relay_one),
        .m_relay_two     (m_relay_two),
        .m_done_pulse    (m_done_pulse),
        .m_timeout_pulse (m_timeout_pulse),
        .m_ready_flag    (m_ready_flag),
        .m_phase         (m_phase)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Sequencer predictor
    // ------------------------------------------------------------------

    // One tick on a counter that sticks at all ones.
    function automatic timer_t sat_tick(input timer_t t);
        return (&t) ? t : t + 1'b1;
    endfunction

    function automatic bit longer_than(input timer_t t, input dur_t d);
        return 64'(t) > 64'(d);
    endfunction

    // Drive one pulse output on or off; a disabled output leaves the relays alone.
    function automatic void set_relay(input setup_t s, input logic on);
        logic lvl;
        if (s[srs_pkg::SETUP_EN]) begin
            lvl = on ^ s[srs_pkg::SETUP_INV];
            if (s[srs_pkg::SETUP_SEL]) begin
                relay_two_q = lvl;
            end else begin
                relay_one_q = lvl;
            end
        end
    endfunction

    function automatic logic done_level(input logic p1, input logic p2);
        if (!done_cfg[srs_pkg::SETUP_EN]) begin
            return 1'b0;
        end
        return (done_cfg[srs_pkg::SETUP_SEL] ? p2 : p1) ^ done_cfg[srs_pkg::SETUP_INV];
    endfunction

    function automatic loop_result_t predict_pass(input loop_item_t it);
        loop_result_t r;
        r = '0;

        // Timers first, then pulse expiry (indicator before control).
        if (it.tick) begin
            ind_elapsed = sat_tick(ind_elapsed);
            ctl_elapsed = sat_tick(ctl_elapsed);
            work_elapsed = sat_tick(work_elapsed);
        end
        if (ind_armed && longer_than(ind_elapsed, ind_dur)) begin
            set_relay(ind_setup, 1'b0);
            ind_armed = 1'b0;
        end
        if (ctl_armed && longer_than(ctl_elapsed, ctl_dur)) begin
            set_relay(ctl_setup, 1'b0);
            ctl_armed = 1'b0;
        end

        // Phase machine.
        case (phase_q)
            srs_pkg::PH_READY: begin
                if (it.ev_valid && it.prepare) begin
                    phase_q = srs_pkg::PH_PREPARE;
                    set_relay(ind_setup, 1'b0);
                    ind_armed = 1'b0;
                end
            end
            srs_pkg::PH_PREPARE: begin
                if (it.ev_valid) begin
                    if (it.indicator) begin
                        ind_elapsed = '0;
                        set_relay(ind_setup, 1'b1);
                        ind_armed = 1'b1;
                    end else begin
                        set_relay(ind_setup, 1'b0);
                        ind_armed = 1'b0;
                    end
                    if (it.control) begin
                        ctl_elapsed = '0;
                        set_relay(ctl_setup, 1'b1);
                        ctl_armed = 1'b1;
                        work_elapsed = '0;
                        phase_q = srs_pkg::PH_WORK;
                    end else begin
                        phase_q = srs_pkg::PH_READY;
                    end
                end
            end
            srs_pkg::PH_WORK: begin
                if (longer_than(work_elapsed, svc_time)) begin
                    r.timeout_hit = 1'b1;
                    phase_q = srs_pkg::PH_FINAL;
                end else if (done_level(it.pin_one, it.pin_two)) begin
                    set_relay(ctl_setup, 1'b0);
                    ctl_armed = 1'b0;
                    r.done_hit = 1'b1;
                    phase_q = srs_pkg::PH_FINAL;
                end
            end
            default: begin
                phase_q = srs_pkg::PH_READY;
            end
        endcase

        r.relay_one = relay_one_q;
        r.relay_two = relay_two_q;
        r.ready_flag = !done_level(it.pin_one, it.pin_two);
        r.phase = phase_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [1:0] want,
                                          input logic [1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, name, want, got);
            end
        end
    endfunction

    // Predict on every accepted item and check every accepted result.
    always @(posedge aclk) begin : scoreboard
        loop_item_t   seen_item;
        loop_result_t got;
        loop_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_relay_one, m_relay_two, m_done_pulse, m_timeout_pulse,
                       m_ready_flag, m_phase};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with no item waiting for it",
                                 results_seen);
                    end
                end else begin
                    want = expected_results.pop_front();
                    compare_field("relay_one", want.relay_one, got.relay_one);
                    compare_field("relay_two", want.relay_two, got.relay_two);
                    compare_field("done_pulse", want.done_hit, got.done_hit);
                    compare_field("timeout_pulse", want.timeout_hit, got.timeout_hit);
                    compare_field("ready_flag", want.ready_flag, got.ready_flag);
                    compare_field("phase", want.phase, got.phase);
                end
            end
            if (s_valid && s_ready) begin
                seen_item = {s_tick_10ms, s_event_valid, s_evt_prepare, s_evt_indicator,
                             s_evt_control, s_sensor_one, s_sensor_two};
                want = predict_pass(seen_item);
                done_ends += want.done_hit;
                timeout_ends += want.timeout_hit;
                expected_results.push_back(want);
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("no handshake for %0d cycles, giving up", IDLE_LIMIT);
                $display("service_relay_sequencer regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every task starts and ends at a falling edge.
    // ------------------------------------------------------------------

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_item(input logic tick, input logic ev, input logic prep,
                             input logic ind, input logic ctl, input logic p1,
                             input logic p2);
        while (chance(send_idle_pct)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_tick_10ms <= tick;
        s_event_valid <= ev;
        s_evt_prepare <= prep;
        s_evt_indicator <= ind;
        s_evt_control <= ctl;
        s_sensor_one <= p1;
        s_sensor_two <= p2;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop sending and wait until every outstanding result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [srs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [srs_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            srs_pkg::REG_CONTROL_SETUP:      ctl_setup = setup_t'(data);
            srs_pkg::REG_INDICATOR_SETUP:    ind_setup = setup_t'(data);
            srs_pkg::REG_DONE_SETUP:         done_cfg = setup_t'(data);
            srs_pkg::REG_CONTROL_DURATION:   ctl_dur = dur_t'(data);
            srs_pkg::REG_INDICATOR_DURATION: ind_dur = dur_t'(data);
            srs_pkg::REG_SERVICE_TIME:       svc_time = dur_t'(data);
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Full register set, written once the block has gone quiet. The setup
    // registers get junk in their unused upper bits.
    task automatic apply_config(input setup_t ctl, input setup_t ind, input setup_t dn,
                                input dur_t cdur, input dur_t idur, input dur_t svc);
        drain_results();
        repeat (2) @(negedge aclk);
        write_reg(srs_pkg::REG_CONTROL_SETUP, {PAD_W'($urandom), ctl});
        write_reg(srs_pkg::REG_INDICATOR_SETUP, {PAD_W'($urandom), ind});
        write_reg(srs_pkg::REG_DONE_SETUP, {PAD_W'($urandom), dn});
        write_reg(srs_pkg::REG_CONTROL_DURATION, cdur);
        write_reg(srs_pkg::REG_INDICATOR_DURATION, idur);
        write_reg(srs_pkg::REG_SERVICE_TIME, svc);
        write_reg(chance(50) ? REG_SPARE_A : REG_SPARE_B,
                  srs_pkg::CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // Sensor pins with the selected done pin active at the given rate.
    function automatic logic [1:0] pick_pins(input int active_pct);
        logic [1:0] pins;
        logic lvl;
        pins = 2'($urandom);
        lvl = chance(active_pct) ^ done_cfg[srs_pkg::SETUP_INV];
        if (done_cfg[srs_pkg::SETUP_EN]) begin
            if (done_cfg[srs_pkg::SETUP_SEL]) begin
                pins[0] = lvl;
            end else begin
                pins[1] = lvl;
            end
        end
        return pins;
    endfunction

    task automatic send_loose_item(input int tick_pct, input int ev_pct,
                                   input int done_pct);
        logic [1:0] pins;
        pins = pick_pins(done_pct);
        send_item(chance(tick_pct), chance(ev_pct), chance(50), chance(50), chance(50),
                  pins[1], pins[0]);
    endtask

    // A well-formed service pass: prepare request, arm event, work, final,
    // then some ticks so the pulses can run out.
    task automatic run_service_pass();
        logic [1:0] pins;
        pins = pick_pins(10);
        send_item(chance(50), 1'b1, 1'b1, chance(50), chance(50), pins[1], pins[0]);
        repeat ($urandom_range(0, 2)) send_loose_item(50, 0, 10);
        pins = pick_pins(10);
        send_item(chance(50), 1'b1, chance(50), chance(70), chance(85), pins[1], pins[0]);
        repeat ($urandom_range(1, 14)) send_loose_item(60, 15, 12);
        send_loose_item(50, 10, 10);
        repeat ($urandom_range(0, 3)) send_loose_item(70, 0, 30);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: both outputs disabled, done disabled.
    task automatic test_idle_after_reset();
        send_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // An event without the prepare bit is dropped in ready.
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // Normal pass ended by the done sensor; indicator runs out on its own.
    task automatic test_done_sequence();
        apply_config(setup_t'(3'b001), setup_t'(3'b101), setup_t'(3'b001),
                     dur_t'(2), dur_t'(1), dur_t'(5));
        send_item(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        // The unselected pin must not end the work phase.
        send_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        // Events in final are ignored.
        send_item(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // Prepare without control returns to ready; zero service time expires
    // on the first tick in work, with an inverted control pulse.
    task automatic test_timeout_and_abort();
        apply_config(setup_t'(3'b011), setup_t'(3'b000), setup_t'(3'b000),
                     dur_t'(0), dur_t'(0), dur_t'(0));
        send_item(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // Both pulses on the second relay, maximum durations, inverted done on
    // the second pin: the later drive wins.
    task automatic test_shared_relay_extremes();
        apply_config(setup_t'(3'b111), setup_t'(3'b101), setup_t'(3'b111),
                     dur_t'(16'hFFFF), dur_t'(16'hFFFF), dur_t'(16'hFFFF));
        send_item(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    endtask

    // Random passes over several register settings and idling patterns.
    task automatic test_random_passes();
        int target;
        bit paused;
        dur_t cdur;
        dur_t idur;
        for (int k = 0; k < RANDOM_SETTINGS; k++) begin
            if (k == 0) begin
                apply_config('1, '1, '1, '1, '1, '1);
            end else if (k == 1) begin
                apply_config('0, '0, '0, '0, '0, '0);
            end else begin
                cdur = chance(15) ? dur_t'(16'hFFFF) : dur_t'($urandom_range(0, 15));
                idur = chance(15) ? dur_t'(16'hFFFF) : dur_t'($urandom_range(0, 15));
                apply_config(setup_t'($urandom), setup_t'($urandom), setup_t'($urandom),
                             cdur, idur, dur_t'($urandom_range(0, 24)));
            end
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            target = items_sent + ITEMS_PER_SETTING;
            paused = 1'b0;
            while (items_sent < target) begin
                if (chance(80)) begin
                    run_service_pass();
                end else begin
                    repeat ($urandom_range(1, 4)) send_loose_item(50, 60, 50);
                end
                // Hold the sender until the result side has caught up.
                if (!paused && k % 3 == 0 && items_sent >= target - ITEMS_PER_SETTING / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_idle_after_reset();
        test_done_sequence();
        test_timeout_and_abort();
        test_shared_relay_extremes();
        test_random_passes();

        drain_results();
        repeat (4) @(negedge aclk);
        $display("Ran %0d items through %0d register settings and four idling patterns.",
                 items_sent, settings_used);
        $display("Work ended %0d times on the done sensor and %0d on timeout; %0d mismatches.",
                 done_ends, timeout_ends, mismatches);
        if (mismatches == 0) begin
            $display("service_relay_sequencer regression: pass");
        end else begin
            $display("service_relay_sequencer regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/srs_pkg.sv
sv/service_relay_sequencer.sv
sv/srs_checker.sv
tb/sv/tb.sv
